/* hdl/c8080_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c8080_pkg: shared types and constants of the 8080 subset execute block
// Holds the word kinds, the queue entry layout, the result layout and the
// opcode codes used by the front and back parts.
// ----------------------------------------------------------------------------
package c8080_pkg;

    // Default memory address width; the memory holds 2**ADDR_BITS bytes.
    localparam int ADDR_BITS_DEF = 16;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes carried in tuser.
    localparam logic [1:0] OPN_WRITE = 2'd0;
    localparam logic [1:0] OPN_EXEC  = 2'd1;
    localparam logic [1:0] OPN_READ  = 2'd2;

    // Classified kind of one input word.
    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_EXEC  = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } kind_t;

    // One queued word.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [7:0]  wbyte;
    } item_t;

    // Result word, laid out so that the program counter sits in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  opcode;
        logic [7:0]  read_byte;
        logic [4:0]  flags;
        logic [7:0]  reg_l;
        logic [7:0]  reg_h;
        logic [7:0]  reg_e;
        logic [7:0]  reg_d;
        logic [7:0]  reg_c;
        logic [7:0]  reg_b;
        logic [7:0]  acc;
        logic [15:0] pc;
    } result_t;

    // Flag bit positions.
    localparam int FLAG_C  = 0;
    localparam int FLAG_P  = 1;
    localparam int FLAG_AC = 2;
    localparam int FLAG_Z  = 3;
    localparam int FLAG_S  = 4;

    // Opcodes that do something; all others behave as one-byte NOPs.
    localparam logic [7:0] OPC_LXI_B  = 8'h01;
    localparam logic [7:0] OPC_STAX_B = 8'h02;
    localparam logic [7:0] OPC_INX_B  = 8'h03;
    localparam logic [7:0] OPC_INR_B  = 8'h04;
    localparam logic [7:0] OPC_DCR_B  = 8'h05;
    localparam logic [7:0] OPC_MVI_B  = 8'h06;
    localparam logic [7:0] OPC_RLC    = 8'h07;
    localparam logic [7:0] OPC_DAD_B  = 8'h09;
    localparam logic [7:0] OPC_LDAX_B = 8'h0A;
    localparam logic [7:0] OPC_DCX_B  = 8'h0B;
    localparam logic [7:0] OPC_INR_C  = 8'h0C;
    localparam logic [7:0] OPC_DCR_C  = 8'h0D;
    localparam logic [7:0] OPC_MVI_C  = 8'h0E;
    localparam logic [7:0] OPC_RRC    = 8'h0F;
    localparam logic [7:0] OPC_LXI_D  = 8'h11;
    localparam logic [7:0] OPC_STAX_D = 8'h12;

    // Sign, zero, aux carry and even parity of an 8-bit result; carry is kept.
    function automatic logic [4:0] szp_flags(input logic [7:0] res, input logic ac,
                                             input logic carry);
        logic [4:0] f;
        f          = '0;
        f[FLAG_S]  = res[7];
        f[FLAG_Z]  = (res == 8'h00);
        f[FLAG_AC] = ac;
        f[FLAG_P]  = ~(^res);
        f[FLAG_C]  = carry;
        return f;
    endfunction

endpackage
`default_nettype wire

/* hdl/c8080_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c8080_front: input side of the 8080 subset execute block
// Accepts input words, classifies the operation and holds them in a short
// queue that the back part drains at its own pace.
// ----------------------------------------------------------------------------
module c8080_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [23:0]         s_axis_tdata,
    input  wire logic [1:0]          s_axis_tuser,
    output logic                     q_valid,
    output c8080_pkg::item_t         q_item,
    input  wire logic                q_pop
);
    import c8080_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    item_t             in_item;
    logic              push;
    logic              pop;

    // Classify the incoming word.
    always_comb
    begin
        in_item.addr  = s_axis_tdata[15:0];
        in_item.wbyte = s_axis_tdata[23:16];
        unique case (s_axis_tuser)
            OPN_WRITE: in_item.kind = K_WRITE;
            OPN_EXEC:  in_item.kind = K_EXEC;
            OPN_READ:  in_item.kind = K_READ;
            default:   in_item.kind = K_NONE;
        endcase
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && q_valid;
    assign q_valid       = (count_reg != '0);
    assign q_item        = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/c8080_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c8080_back: execution side of the 8080 subset execute block
// Holds the register set, flags, program counter and the single-port byte
// memory, runs each queued word through a sequencer and registers the result.
// ----------------------------------------------------------------------------
module c8080_back #(
    parameter int ADDR_BITS = c8080_pkg::ADDR_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire c8080_pkg::item_t    q_item,
    output logic                     q_pop,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output c8080_pkg::result_t       result
);
    import c8080_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RDWAIT = 8'b0000_0010,
        S_OPC    = 8'b0000_0100,
        S_LOB    = 8'b0000_1000,
        S_HIB    = 8'b0001_0000,
        S_EXEC   = 8'b0010_0000,
        S_LDAX   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    kind_t          kind_reg, kind_next;
    logic [7:0]     a_reg, a_next;
    logic [7:0]     b_reg, b_next;
    logic [7:0]     c_reg, c_next;
    logic [7:0]     d_reg, d_next;
    logic [7:0]     e_reg, e_next;
    logic [7:0]     h_reg, h_next;
    logic [7:0]     l_reg, l_next;
    logic [4:0]     flags_reg, flags_next;
    logic [15:0]    pc_reg, pc_next;
    logic [7:0]     opc_reg, opc_next;
    logic [7:0]     lo_reg, lo_next;
    logic [7:0]     hi_reg, hi_next;
    logic [7:0]     rd_reg, rd_next;
    logic           out_valid_reg, out_valid_next;
    result_t        out_reg;
    logic           out_load;

    logic [7:0]           mem [MEM_DEPTH];
    logic [7:0]           mem_q;
    logic [ADDR_BITS-1:0] mem_addr;
    logic                 mem_we;
    logic                 mem_re;
    logic [7:0]           mem_wdata;

    logic [15:0] pc_p1;
    logic [15:0] pc_p2;
    logic [15:0] bc_pair;
    logic [15:0] de_pair;
    logic [15:0] bc_inc;
    logic [15:0] bc_dec;
    logic [16:0] dad_sum;
    logic [7:0]  b_inc, b_dec, c_inc, c_dec;

    assign pc_p1   = pc_reg + 16'd1;
    assign pc_p2   = pc_reg + 16'd2;
    assign bc_pair = {b_reg, c_reg};
    assign de_pair = {d_reg, e_reg};
    assign bc_inc  = bc_pair + 16'd1;
    assign bc_dec  = bc_pair - 16'd1;
    assign dad_sum = {1'b0, h_reg, l_reg} + {1'b0, bc_pair};
    assign b_inc   = b_reg + 8'd1;
    assign b_dec   = b_reg - 8'd1;
    assign c_inc   = c_reg + 8'd1;
    assign c_dec   = c_reg - 8'd1;

    // Sequencer: execute words fetch three bytes, then at most one data access.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        h_next     = h_reg;
        l_next     = l_reg;
        flags_next = flags_reg;
        pc_next    = pc_reg;
        opc_next   = opc_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        rd_next    = rd_reg;
        mem_addr   = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wdata  = a_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_item.kind;
                    rd_next   = '0;
                    opc_next  = '0;
                    unique case (q_item.kind)
                        K_WRITE:
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = q_item.addr[ADDR_BITS-1:0];
                            mem_wdata  = q_item.wbyte;
                            state_next = S_DONE;
                        end
                        K_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_addr   = q_item.addr[ADDR_BITS-1:0];
                            state_next = S_RDWAIT;
                        end
                        K_EXEC:
                        begin
                            mem_re     = 1'b1;
                            mem_addr   = pc_reg[ADDR_BITS-1:0];
                            state_next = S_OPC;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                rd_next    = mem_q;
                state_next = S_DONE;
            end
            S_OPC:
            begin
                opc_next   = mem_q;
                mem_re     = 1'b1;
                mem_addr   = pc_p1[ADDR_BITS-1:0];
                state_next = S_LOB;
            end
            S_LOB:
            begin
                lo_next    = mem_q;
                mem_re     = 1'b1;
                mem_addr   = pc_p2[ADDR_BITS-1:0];
                state_next = S_HIB;
            end
            S_HIB:
            begin
                hi_next    = mem_q;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                pc_next    = pc_p1;
                unique case (opc_reg)
                    OPC_LXI_B:
                    begin
                        b_next  = hi_reg;
                        c_next  = lo_reg;
                        pc_next = pc_reg + 16'd3;
                    end
                    OPC_STAX_B:
                    begin
                        mem_we   = 1'b1;
                        mem_addr = bc_pair[ADDR_BITS-1:0];
                    end
                    OPC_INX_B:
                    begin
                        {b_next, c_next} = bc_inc;
                    end
                    OPC_INR_B:
                    begin
                        b_next     = b_inc;
                        flags_next = szp_flags(b_inc, b_reg[3:0] == 4'hF, flags_reg[FLAG_C]);
                    end
                    OPC_DCR_B:
                    begin
                        b_next     = b_dec;
                        flags_next = szp_flags(b_dec, b_dec[3:0] != 4'hF, flags_reg[FLAG_C]);
                    end
                    OPC_MVI_B:
                    begin
                        b_next  = lo_reg;
                        pc_next = pc_p2;
                    end
                    OPC_RLC:
                    begin
                        flags_next[FLAG_C] = a_reg[7];
                        a_next             = {a_reg[6:0], a_reg[7]};
                    end
                    OPC_DAD_B:
                    begin
                        flags_next[FLAG_C] = dad_sum[16];
                        {h_next, l_next}   = dad_sum[15:0];
                    end
                    OPC_LDAX_B:
                    begin
                        mem_re     = 1'b1;
                        mem_addr   = bc_pair[ADDR_BITS-1:0];
                        state_next = S_LDAX;
                    end
                    OPC_DCX_B:
                    begin
                        {b_next, c_next} = bc_dec;
                    end
                    OPC_INR_C:
                    begin
                        c_next     = c_inc;
                        flags_next = szp_flags(c_inc, c_reg[3:0] == 4'hF, flags_reg[FLAG_C]);
                    end
                    OPC_DCR_C:
                    begin
                        c_next     = c_dec;
                        flags_next = szp_flags(c_dec, c_dec[3:0] != 4'hF, flags_reg[FLAG_C]);
                    end
                    OPC_MVI_C:
                    begin
                        c_next  = lo_reg;
                        pc_next = pc_p2;
                    end
                    OPC_RRC:
                    begin
                        flags_next[FLAG_C] = a_reg[0];
                        a_next             = {a_reg[0], a_reg[7:1]};
                    end
                    OPC_LXI_D:
                    begin
                        d_next  = hi_reg;
                        e_next  = lo_reg;
                        pc_next = pc_reg + 16'd3;
                    end
                    OPC_STAX_D:
                    begin
                        mem_we   = 1'b1;
                        mem_addr = de_pair[ADDR_BITS-1:0];
                    end
                    default:
                    begin
                        pc_next = pc_p1;
                    end
                endcase
            end
            S_LDAX:
            begin
                a_next     = mem_q;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_NONE;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            h_reg         <= '0;
            l_reg         <= '0;
            flags_reg     <= '0;
            pc_reg        <= '0;
            opc_reg       <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            e_reg         <= e_next;
            h_reg         <= h_next;
            l_reg         <= l_next;
            flags_reg     <= flags_next;
            pc_reg        <= pc_next;
            opc_reg       <= opc_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operand bytes and the result word, payload only.
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (out_load)
        begin
            out_reg.pad       <= '0;
            out_reg.opcode    <= opc_reg;
            out_reg.read_byte <= rd_reg;
            out_reg.flags     <= flags_reg;
            out_reg.reg_l     <= l_reg;
            out_reg.reg_h     <= h_reg;
            out_reg.reg_e     <= e_reg;
            out_reg.reg_d     <= d_reg;
            out_reg.reg_c     <= c_reg;
            out_reg.reg_b     <= b_reg;
            out_reg.acc       <= a_reg;
            out_reg.pc        <= pc_reg;
        end
    end

    // Single-port byte memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_q <= mem[mem_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign result        = out_reg;

    // A word leaves the queue only when the sequencer is free.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped while the sequencer was busy");

    // Memory is written only by a write word or by a store instruction.
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_IDLE) || (state_reg == S_EXEC)))
        else $error("memory written outside a write word or a store");

    // The program counter moves only when an instruction completes.
    a_pc_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(pc_reg))
        else $error("program counter changed outside execution");

    // Words other than execute report a zero opcode.
    a_opc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (kind_reg != K_EXEC)) |=> (out_reg.opcode == 8'h00))
        else $error("non-execute word reported an opcode");

endmodule
`default_nettype wire

/* hdl/cpu8080_opcode_subset_execute.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8080_opcode_subset_execute: 8080-style subset execution unit
// Executes a subset of 8080 opcodes against a private register set and a
// byte memory, driven by a stream of memory write, execute and read words.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_axis_*) takes one word per handshake: tuser holds
//   the operation (0 write byte, 1 execute one instruction, 2 read byte, 3 no
//   effect), tdata holds the byte address and the byte to store.
//   The master channel (m_axis_*) returns exactly one result word per input
//   word, in order: program counter, A, B, C, D, E, H, L, flags, the byte
//   read and the opcode executed.
//   Words pass through a two-entry queue into a sequencer that owns a single
//   port on the byte memory. From queue head to result register a write or
//   no-effect word goes straight to the final step, a read word waits for
//   the read data, an execute word fetches its opcode and two operand bytes
//   one per cycle on that port, then executes, and LDAX adds a data read;
//   the queue is registered. The sequencer takes a new word only once the
//   last result is loaded; execute words are paced by fetches on that port.
//   Reset clears the registers, flags, program counter, queue and output
//   valid flag; memory contents are undefined until written.
//   When the receiver stalls, the finished result is held and the sequencer
//   waits in its final step, while the queue keeps accepting words until full.
// ----------------------------------------------------------------------------
module cpu8080_opcode_subset_execute #(
    parameter int ADDR_BITS = c8080_pkg::ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // mem_address[15:0], write_byte[23:16]
    input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata    // pc_value[15:0], acc_value[23:16],
                                             // reg_b..reg_l_value[71:24], flag_bits[76:72],
                                             // read_byte[84:77], executed_opcode[92:85]
);
    import c8080_pkg::*;

    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t result;

    // Front: accept and classify words into the queue.
    c8080_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // Back: execute queued words and hold the result.
    c8080_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .result        (result)
    );

    assign m_axis_tdata = result;

endmodule
`default_nettype wire
